>>> sv/prf_pkg.sv
// Shared types, constants and helpers for the page replacement fault counter.
`default_nettype none
package prf_pkg;

	localparam int PAGE_BITS  = 12;
	localparam int CFG_W      = 7;
	localparam int CNT_W      = 32;
	localparam int FRAMES_DEF = 64;
	localparam int NPOL       = 5;

	localparam int P_FIFO  = 0;
	localparam int P_LRU   = 1;
	localparam int P_LFU   = 2;
	localparam int P_MFU   = 3;
	localparam int P_CLOCK = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [CNT_W-1:0] FREQ_INIT = CNT_W'(1);
	localparam logic [CNT_W-1:0] AGE_INIT  = CNT_W'(1);

	typedef struct packed {
		logic [PAGE_BITS-1:0] page_number;
	} in_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] frames_in_use;
	} cfg_item_t;

	typedef struct packed {
		logic             fifo_miss;
		logic             lru_miss;
		logic             lfu_miss;
		logic             mfu_miss;
		logic             clock_fault;
		logic [CNT_W-1:0] fifo_total;
		logic [CNT_W-1:0] lru_total;
		logic [CNT_W-1:0] lfu_total;
		logic [CNT_W-1:0] mfu_total;
		logic [CNT_W-1:0] clock_total;
	} out_item_t;

	// frame entry: page plus age, stamp or count
	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic [CNT_W-1:0]     aux;
	} ent_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_LOAD,
		DP_SCAN,
		DP_UPDATE,
		DP_TAIL,
		DP_PICK,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   last_tail;
	} dp_cmd_t;

	typedef struct packed {
		logic clk_hit;
		logic clk_empty;
		logic clk_mark;
	} dp_status_t;

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

>>> sv/prf_if.sv
// Valid/ready channel interfaces for input, result and configuration transactions.
`default_nettype none
interface prf_in_if;
	logic              valid;
	logic              ready;
	prf_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface prf_out_if;
	logic               valid;
	logic               ready;
	prf_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface prf_cfg_if;
	logic               valid;
	logic               ready;
	prf_pkg::cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/page_replacement_fault_counter_top.sv
// Top level: five-policy page replacement fault counter.
// One transaction at a time; n = active frames. A reference that hits under second
// chance takes a scan and an update; otherwise a tail pass too, plus one more for each
// marked frame that second chance passes over (at most n of them). Each pass reads one
// frame per cycle from every policy memory. Reset clears valid bits, totals and the
// reference counter at once; no clearing pass. The frame count register resets to 64.
`default_nettype none
module page_replacement_fault_counter_top #(
	parameter int FRAMES = prf_pkg::FRAMES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	prf_in_if.sink    in_ch,
	prf_out_if.source out_ch,
	prf_cfg_if.sink   cfg_ch
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	prf_pkg::dp_cmd_t    cmd;
	prf_pkg::dp_status_t status;
	logic [IW-1:0]       idx;

	assign cfg_ch.ready = 1'b1;

	prf_ctrl #(.FRAMES(FRAMES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cfg_valid (cfg_ch.valid),
		.cfg_value (cfg_ch.data.frames_in_use),
		.cmd       (cmd),
		.idx       (idx),
		.status    (status)
	);

	prf_dp #(.FRAMES(FRAMES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx         (idx),
		.page_number (in_ch.data.page_number),
		.status      (status),
		.result      (out_ch.data)
	);

endmodule
`default_nettype wire

>>> sv/prf_ctrl.sv
// Controller: sequences scan, update and second chance passes per transaction.
`default_nettype none
module prf_ctrl #(
	parameter int FRAMES = prf_pkg::FRAMES_DEF,
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int NW = $clog2(FRAMES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       cfg_valid,
	input  logic [prf_pkg::CFG_W-1:0]  cfg_value,
	output prf_pkg::dp_cmd_t           cmd,
	output logic [IW-1:0]              idx,
	input  prf_pkg::dp_status_t        status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_WAIT,
		S_UPDATE,
		S_TAIL,
		S_TAIL_WAIT,
		S_TAIL_CHK,
		S_FINISH
	} state_t;

	state_t                     state_q;
	logic [prf_pkg::CFG_W-1:0]  cfg_q;
	logic [IW-1:0]              i_q;
	logic [NW-1:0]              iter_q;
	logic                       tail_last_q;
	logic                       out_valid_q;
	logic [NW-1:0]              n_c;
	logic [IW-1:0]              n_m1;
	logic                       fin_go;

	always_comb begin
		if (cfg_q == '0) begin
			n_c = NW'(1);
		end else if (int'(cfg_q) > FRAMES) begin
			n_c = NW'(FRAMES);
		end else begin
			n_c = NW'(cfg_q);
		end
		n_m1 = IW'(n_c - 1'b1);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign idx       = i_q;
	assign fin_go    = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.op        = prf_pkg::DP_NONE;
		cmd.last_tail = tail_last_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) cmd.op = prf_pkg::DP_LOAD;
			end
			S_SCAN:     cmd.op = prf_pkg::DP_SCAN;
			S_UPDATE:   cmd.op = prf_pkg::DP_UPDATE;
			S_TAIL:     cmd.op = prf_pkg::DP_TAIL;
			S_TAIL_CHK: cmd.op = prf_pkg::DP_PICK;
			S_FINISH: begin
				if (fin_go) cmd.op = prf_pkg::DP_FINISH;
			end
			default:    cmd.op = prf_pkg::DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= prf_pkg::CFG_RESET;
			i_q         <= '0;
			iter_q      <= '0;
			tail_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) cfg_q <= cfg_value;
			if (out_valid_q && out_ready && !fin_go) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						i_q     <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (i_q == n_m1) begin
						state_q <= S_SCAN_WAIT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_SCAN_WAIT: state_q <= S_UPDATE;
				S_UPDATE: begin
					iter_q <= '0;
					i_q    <= '0;
					if (status.clk_hit) begin
						state_q <= S_FINISH;
					end else begin
						tail_last_q <= status.clk_empty || !status.clk_mark;
						state_q     <= S_TAIL;
					end
				end
				S_TAIL: begin
					if (i_q == n_m1) begin
						state_q <= S_TAIL_WAIT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_TAIL_WAIT: state_q <= tail_last_q ? S_FINISH : S_TAIL_CHK;
				S_TAIL_CHK: begin
					iter_q      <= iter_q + 1'b1;
					i_q         <= '0;
					tail_last_q <= !((({1'b0, iter_q} + 1'b1) < {1'b0, n_c})
						&& status.clk_mark);
					state_q     <= S_TAIL;
				end
				S_FINISH: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/prf_dp.sv
// Datapath: frame memories, scan trackers, fault totals and result register.
`default_nettype none
module prf_dp #(
	parameter int FRAMES = prf_pkg::FRAMES_DEF,
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prf_pkg::dp_cmd_t              cmd,
	input  logic [IW-1:0]                 idx,
	input  logic [prf_pkg::PAGE_BITS-1:0] page_number,
	output prf_pkg::dp_status_t           status,
	output prf_pkg::out_item_t            result
);

	localparam int NP = prf_pkg::NPOL;
	localparam int PB = prf_pkg::PAGE_BITS;
	localparam int CW = prf_pkg::CNT_W;
	localparam int PF = prf_pkg::P_FIFO;
	localparam int PL = prf_pkg::P_LRU;
	localparam int PQ = prf_pkg::P_LFU;
	localparam int PM = prf_pkg::P_MFU;
	localparam int PC = prf_pkg::P_CLOCK;

	prf_pkg::ent_t      mem_q [NP][FRAMES];
	logic               mark_mem_q [FRAMES];
	prf_pkg::ent_t      rd_s1 [NP];
	logic               mark_s1;
	logic [NP-1:0]      v_s1;
	logic [FRAMES-1:0]  vld_q [NP];
	prf_pkg::dp_cmd_t   cmd_s1;
	logic [IW-1:0]      idx_s1;

	logic [PB-1:0]      pg_q;
	logic [CW-1:0]      refclk_q;
	logic [NP-1:0]      hit_q;
	logic [NP-1:0]      emp_q;
	logic [IW-1:0]      hit_idx_q [NP];
	logic [CW-1:0]      hit_val_q [NP];
	logic [IW-1:0]      emp_idx_q [NP];
	logic [IW-1:0]      best_idx_q [NP];
	logic [CW-1:0]      best_val_q [NP];
	logic [PB-1:0]      best_pg_q [NP];
	logic               best_mark_q;
	logic [IW-1:0]      clk_k_q;
	logic [CW-1:0]      tot_q [NP];
	prf_pkg::out_item_t res_q;

	prf_pkg::ent_t      e_s [NP];
	logic [CW-1:0]      val_s [NP];
	logic [NP-1:0]      better_s;
	logic [IW-1:0]      kk [NP];
	logic [NP-1:0]      we;
	logic [IW-1:0]      wa [NP];
	prf_pkg::ent_t      wd [NP];
	logic [NP-1:0]      sv;
	logic [IW-1:0]      sva [NP];
	logic               mark_we;
	logic [IW-1:0]      mark_wa;
	logic               mark_wd;
	logic               mark_s;
	logic [PB-1:0]      clk_pg;
	logic               scan, tail, at_k, first;
	logic [CW-1:0]      tot_n [NP];

	always_comb begin
		scan  = (cmd_s1.op == prf_pkg::DP_SCAN);
		tail  = (cmd_s1.op == prf_pkg::DP_TAIL);
		at_k  = (idx_s1 == clk_k_q);
		first = (idx_s1 == '0);
		for (int p = 0; p < NP; p++) begin
			e_s[p]   = v_s1[p] ? rd_s1[p] : '0;
			kk[p]    = emp_q[p] ? emp_idx_q[p] : best_idx_q[p];
			tot_n[p] = hit_q[p] ? tot_q[p] : prf_pkg::inc_sat(tot_q[p]);
		end
		val_s[PF] = v_s1[PF] ? prf_pkg::inc_sat(e_s[PF].aux) : e_s[PF].aux;
		val_s[PL] = e_s[PL].aux;
		val_s[PQ] = e_s[PQ].aux;
		val_s[PM] = e_s[PM].aux;
		if (tail && at_k) begin
			val_s[PC] = prf_pkg::AGE_INIT;
		end else begin
			val_s[PC] = v_s1[PC] ? prf_pkg::inc_sat(e_s[PC].aux) : e_s[PC].aux;
		end
		clk_pg = (tail && at_k && cmd_s1.last_tail) ? pg_q : e_s[PC].page;
		mark_s = (tail && at_k) ? 1'b0 : mark_s1;

		better_s[PF] = val_s[PF] > best_val_q[PF];
		better_s[PL] = val_s[PL] < best_val_q[PL];
		better_s[PQ] = (val_s[PQ] < best_val_q[PQ]) ||
			((val_s[PQ] == best_val_q[PQ]) && (e_s[PQ].page < best_pg_q[PQ]));
		better_s[PM] = (val_s[PM] > best_val_q[PM]) ||
			((val_s[PM] == best_val_q[PM]) && (e_s[PM].page < best_pg_q[PM]));
		better_s[PC] = val_s[PC] > best_val_q[PC];

		we      = '0;
		sv      = '0;
		mark_we = 1'b0;
		mark_wa = idx_s1;
		mark_wd = 1'b0;
		for (int p = 0; p < NP; p++) begin
			wa[p]  = idx_s1;
			wd[p]  = '0;
			sva[p] = idx_s1;
		end

		if (scan) begin
			we[PF] = 1'b1;
			wd[PF] = '{page: e_s[PF].page, aux: val_s[PF]};
			we[PC] = 1'b1;
			wd[PC] = '{page: e_s[PC].page, aux: val_s[PC]};
		end else if (tail) begin
			we[PC] = 1'b1;
			wd[PC] = '{page: clk_pg, aux: val_s[PC]};
			if (at_k) begin
				mark_we = 1'b1;
				sv[PC]  = cmd_s1.last_tail;
			end
		end else if (cmd.op == prf_pkg::DP_UPDATE) begin
			if (!hit_q[PF]) begin
				we[PF]  = 1'b1;
				wa[PF]  = kk[PF];
				wd[PF]  = '{page: pg_q, aux: prf_pkg::AGE_INIT};
				sv[PF]  = 1'b1;
				sva[PF] = kk[PF];
			end
			we[PL]  = 1'b1;
			wa[PL]  = hit_q[PL] ? hit_idx_q[PL] : kk[PL];
			wd[PL]  = '{page: pg_q, aux: refclk_q};
			sv[PL]  = !hit_q[PL];
			sva[PL] = kk[PL];
			for (int p = PQ; p <= PM; p++) begin
				we[p]  = 1'b1;
				wa[p]  = hit_q[p] ? hit_idx_q[p] : kk[p];
				wd[p]  = '{page: pg_q, aux: hit_q[p] ?
					prf_pkg::inc_sat(hit_val_q[p]) : prf_pkg::FREQ_INIT};
				sv[p]  = !hit_q[p];
				sva[p] = kk[p];
			end
			if (hit_q[PC]) begin
				mark_we = 1'b1;
				mark_wa = hit_idx_q[PC];
				mark_wd = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < NP; p++) begin
			if (we[p]) mem_q[p][wa[p]] <= wd[p];
			rd_s1[p] <= mem_q[p][idx];
		end
		if (mark_we) mark_mem_q[mark_wa] <= mark_wd;
		mark_s1 <= mark_mem_q[idx];
		if (cmd.op == prf_pkg::DP_FINISH) begin
			res_q.fifo_miss   <= !hit_q[PF];
			res_q.lru_miss    <= !hit_q[PL];
			res_q.lfu_miss    <= !hit_q[PQ];
			res_q.mfu_miss    <= !hit_q[PM];
			res_q.clock_fault <= !hit_q[PC];
			res_q.fifo_total  <= tot_n[PF];
			res_q.lru_total   <= tot_n[PL];
			res_q.lfu_total   <= tot_n[PQ];
			res_q.mfu_total   <= tot_n[PM];
			res_q.clock_total <= tot_n[PC];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NP; p++) begin
				vld_q[p]      <= '0;
				hit_idx_q[p]  <= '0;
				hit_val_q[p]  <= '0;
				emp_idx_q[p]  <= '0;
				best_idx_q[p] <= '0;
				best_val_q[p] <= '0;
				best_pg_q[p]  <= '0;
				tot_q[p]      <= '0;
			end
			v_s1        <= '0;
			cmd_s1      <= '{op: prf_pkg::DP_NONE, last_tail: 1'b0};
			idx_s1      <= '0;
			pg_q        <= '0;
			refclk_q    <= '0;
			hit_q       <= '0;
			emp_q       <= '0;
			best_mark_q <= 1'b0;
			clk_k_q     <= '0;
		end else begin
			cmd_s1 <= cmd;
			idx_s1 <= idx;
			for (int p = 0; p < NP; p++) begin
				v_s1[p] <= vld_q[p][idx];
				if (sv[p]) vld_q[p][sva[p]] <= 1'b1;
			end
			if (cmd.op == prf_pkg::DP_LOAD) begin
				pg_q     <= page_number;
				refclk_q <= prf_pkg::inc_sat(refclk_q);
				hit_q    <= '0;
				emp_q    <= '0;
			end
			if (scan) begin
				for (int p = 0; p < NP; p++) begin
					if (v_s1[p] && (e_s[p].page == pg_q) && !hit_q[p]) begin
						hit_q[p]     <= 1'b1;
						hit_idx_q[p] <= idx_s1;
						hit_val_q[p] <= e_s[p].aux;
					end
					if (!v_s1[p] && !emp_q[p]) begin
						emp_q[p]     <= 1'b1;
						emp_idx_q[p] <= idx_s1;
					end
				end
			end
			for (int p = 0; p < NP; p++) begin
				if ((scan || (tail && p == PC)) && (first || better_s[p])) begin
					best_idx_q[p] <= idx_s1;
					best_val_q[p] <= val_s[p];
					best_pg_q[p]  <= e_s[p].page;
					if (p == PC) best_mark_q <= mark_s;
				end
			end
			if (cmd.op == prf_pkg::DP_UPDATE) clk_k_q <= kk[PC];
			if (cmd.op == prf_pkg::DP_PICK) clk_k_q <= best_idx_q[PC];
			if (cmd.op == prf_pkg::DP_FINISH) begin
				for (int p = 0; p < NP; p++) tot_q[p] <= tot_n[p];
			end
		end
	end

	assign status.clk_hit   = hit_q[PC];
	assign status.clk_empty = emp_q[PC];
	assign status.clk_mark  = best_mark_q;
	assign result           = res_q;

endmodule
`default_nettype wire

>>> sv/prf_check.sv
// Port-level assertions for the fault counter, bound to the top level.
`default_nettype none
module prf_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      fifo_miss,
	input logic [prf_pkg::CNT_W-1:0] fifo_total,
	input logic                      lru_miss,
	input logic [prf_pkg::CNT_W-1:0] lru_total
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a transaction is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fifo_total))
		else $error("stalled result changed");

	a_fifo_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fifo_miss |-> fifo_total != '0)
		else $error("FIFO fault with zero total");

	a_lru_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lru_miss |-> lru_total != '0)
		else $error("LRU fault with zero total");

endmodule

bind page_replacement_fault_counter_top prf_check u_prf_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.fifo_miss  (out_ch.data.fifo_miss),
	.fifo_total (out_ch.data.fifo_total),
	.lru_miss   (out_ch.data.lru_miss),
	.lru_total  (out_ch.data.lru_total)
);
`default_nettype wire

>>> bench/prf_fault_checker.sv
// Checker: predicts fault flags and totals for every reference and compares the results.
module prf_fault_checker (
	input  logic clk,
	input  logic arst_n,
	prf_in_if    in_mon,
	prf_out_if   out_mon,
	prf_cfg_if   cfg_mon,
	output int   fails
);

	localparam int NF  = prf_pkg::FRAMES_DEF;
	localparam int NP  = prf_pkg::NPOL;
	localparam int PB  = prf_pkg::PAGE_BITS;
	localparam int CW  = prf_pkg::CNT_W;
	localparam int FW  = prf_pkg::CFG_W;
	localparam int PF  = prf_pkg::P_FIFO;
	localparam int PL  = prf_pkg::P_LRU;
	localparam int PQ  = prf_pkg::P_LFU;
	localparam int PM  = prf_pkg::P_MFU;
	localparam int PC  = prf_pkg::P_CLOCK;

	bit                 fvalid [NP][NF];
	logic [PB-1:0]      fpage [NP][NF];
	logic [CW-1:0]      faux [NP][NF];
	bit                 cmark [NF];
	logic [CW-1:0]      totals [NP];
	logic [CW-1:0]      refclk;
	logic [FW-1:0]      frames_cfg;
	prf_pkg::out_item_t expected_results [$];
	int                 err_count;

	function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
		return (v == prf_pkg::CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic int find_page(input int p, input int n, input logic [PB-1:0] pg);
		for (int i = 0; i < n; i++)
			if (fvalid[p][i] && fpage[p][i] == pg) return i;
		return -1;
	endfunction

	function automatic int find_free(input int p, input int n);
		for (int i = 0; i < n; i++)
			if (!fvalid[p][i]) return i;
		return -1;
	endfunction

	task automatic age_frames(input int p, input int n, input int skip);
		for (int i = 0; i < n; i++)
			if (i != skip && fvalid[p][i]) faux[p][i] = bump(faux[p][i]);
	endtask

	function automatic int oldest(input int p, input int n);
		int best;
		best = 0;
		for (int i = 1; i < n; i++)
			if (faux[p][i] > faux[p][best]) best = i;
		return best;
	endfunction

	function automatic int stalest(input int n);
		int best;
		best = 0;
		for (int i = 1; i < n; i++)
			if (faux[PL][i] < faux[PL][best]) best = i;
		return best;
	endfunction

	function automatic int by_count(input int p, input int n, input bit most);
		int best;
		bit better;
		best = 0;
		for (int i = 1; i < n; i++) begin
			better = most ? (faux[p][i] > faux[p][best]) : (faux[p][i] < faux[p][best]);
			if (better || (faux[p][i] == faux[p][best] && fpage[p][i] < fpage[p][best]))
				best = i;
		end
		return best;
	endfunction

	task automatic to_tail(input int k, input int n);
		age_frames(PC, n, k);
		faux[PC][k] = prf_pkg::AGE_INIT;
	endtask

	task automatic fill(input int p, input int k, input logic [PB-1:0] pg,
			input logic [CW-1:0] aux);
		fvalid[p][k] = 1'b1;
		fpage[p][k] = pg;
		faux[p][k] = aux;
	endtask

	task automatic predict_faults(input logic [PB-1:0] pg, output prf_pkg::out_item_t r);
		int n, h, e, k;
		bit miss [NP];
		n = (frames_cfg < 1) ? 1 : (frames_cfg > NF) ? NF : int'(frames_cfg);
		refclk = bump(refclk);

		age_frames(PF, n, -1);
		miss[PF] = find_page(PF, n, pg) < 0;
		if (miss[PF]) begin
			e = find_free(PF, n);
			k = (e >= 0) ? e : oldest(PF, n);
			fill(PF, k, pg, prf_pkg::AGE_INIT);
		end

		h = find_page(PL, n, pg);
		miss[PL] = h < 0;
		if (!miss[PL]) begin
			faux[PL][h] = refclk;
		end else begin
			e = find_free(PL, n);
			k = (e >= 0) ? e : stalest(n);
			fill(PL, k, pg, refclk);
		end

		for (int p = PQ; p <= PM; p++) begin
			h = find_page(p, n, pg);
			miss[p] = h < 0;
			if (!miss[p]) begin
				faux[p][h] = bump(faux[p][h]);
			end else begin
				e = find_free(p, n);
				k = (e >= 0) ? e : by_count(p, n, p == PM);
				fill(p, k, pg, prf_pkg::FREQ_INIT);
			end
		end

		age_frames(PC, n, -1);
		h = find_page(PC, n, pg);
		miss[PC] = h < 0;
		if (!miss[PC]) begin
			cmark[h] = 1'b1;
		end else begin
			e = find_free(PC, n);
			if (e >= 0) begin
				k = e;
			end else begin
				k = oldest(PC, n);
				for (int it = 0; it < n && cmark[k]; it++) begin
					cmark[k] = 1'b0;
					to_tail(k, n);
					k = oldest(PC, n);
				end
			end
			fill(PC, k, pg, faux[PC][k]);
			cmark[k] = 1'b0;
			to_tail(k, n);
		end

		for (int p = 0; p < NP; p++)
			if (miss[p]) totals[p] = bump(totals[p]);
		r.fifo_miss   = miss[PF];
		r.lru_miss    = miss[PL];
		r.lfu_miss    = miss[PQ];
		r.mfu_miss    = miss[PM];
		r.clock_fault = miss[PC];
		r.fifo_total  = totals[PF];
		r.lru_total   = totals[PL];
		r.lfu_total   = totals[PQ];
		r.mfu_total   = totals[PM];
		r.clock_total = totals[PC];
	endtask

	task automatic report(input string what, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		err_count++;
	endtask

	task automatic check_field(input string what, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		if (got !== want) report(what, got, want);
	endtask

	task automatic check_flag(input string what, input logic got, input logic want);
		if (got !== want) report(what, CW'(got), CW'(want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		prf_pkg::out_item_t r, w;
		if (!arst_n) begin
			for (int p = 0; p < NP; p++) begin
				totals[p] = '0;
				for (int i = 0; i < NF; i++) begin
					fvalid[p][i] = 1'b0;
					fpage[p][i] = '0;
					faux[p][i] = '0;
				end
			end
			for (int i = 0; i < NF; i++) cmark[i] = 1'b0;
			refclk = '0;
			frames_cfg = prf_pkg::CFG_RESET;
			expected_results.delete();
			err_count = 0;
			fails = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) frames_cfg = cfg_mon.data.frames_in_use;
			if (in_mon.valid && in_mon.ready) begin
				predict_faults(in_mon.data.page_number, r);
				expected_results.push_back(r);
			end
			if (out_mon.valid && out_mon.ready) begin
				r = out_mon.data;
				if (expected_results.size() == 0) begin
					report("unexpected result transaction", CW'(1), CW'(0));
				end else begin
					w = expected_results.pop_front();
					check_flag("fifo_miss", r.fifo_miss, w.fifo_miss);
					check_flag("lru_miss", r.lru_miss, w.lru_miss);
					check_flag("lfu_miss", r.lfu_miss, w.lfu_miss);
					check_flag("mfu_miss", r.mfu_miss, w.mfu_miss);
					check_flag("clock_fault", r.clock_fault, w.clock_fault);
					check_field("fifo_total", r.fifo_total, w.fifo_total);
					check_field("lru_total", r.lru_total, w.lru_total);
					check_field("lfu_total", r.lfu_total, w.lfu_total);
					check_field("mfu_total", r.mfu_total, w.mfu_total);
					check_field("clock_total", r.clock_total, w.clock_total);
				end
			end
			fails = err_count + expected_results.size();
		end
	end
endmodule

>>> bench/tb_page_replacement_fault_counter_top.sv
// Testbench top: drives references and frame count writes, gives the verdict.
module tb_page_replacement_fault_counter_top;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int PB          = prf_pkg::PAGE_BITS;
	localparam int FW          = prf_pkg::CFG_W;
	localparam int NF          = prf_pkg::FRAMES_DEF;

	logic clk;
	logic arst_n;
	int   fails;
	int   sent;
	int   received;
	int   cycles;
	bit   quiet;
	bit   long_hold;

	prf_in_if  in_ch ();
	prf_out_if out_ch ();
	prf_cfg_if cfg_ch ();

	page_replacement_fault_counter_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	prf_fault_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_mon  (in_ch),
		.out_mon (out_ch),
		.cfg_mon (cfg_ch),
		.fails   (fails)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent <= 0;
			received <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) sent <= sent + 1;
			if (out_ch.valid && out_ch.ready) received <= received + 1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** page_replacement_fault_counter_top: FAILED **");
			$finish;
		end
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 19);
	endfunction

	initial begin
		int g;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
			end
			g = draw_gap();
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			@(negedge clk);
		end
	end

	task automatic send_ref(input logic [PB-1:0] pg);
		int g;
		g = draw_gap();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data.page_number <= pg;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (received != sent) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_frames(input logic [FW-1:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data.frames_in_use <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int setting [12];
		int seq [10];
		int n, count;
		logic [PB-1:0] base;
		setting = '{2, 4, 8, 16, 5, 127, 1, 3, 64, 0, 6, 12};
		seq = '{1, 2, 3, 1, 4, 1, 2, 5, 3, 3};
		cycles = 0;
		quiet = 1'b0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, one-frame thrash, victim ties and second chance marks
		send_ref(12'h000); send_ref(12'hFFF); send_ref(12'h000);
		send_ref(12'hAAA); send_ref(12'h555);
		write_frames(FW'(1));
		send_ref(12'd1); send_ref(12'd2); send_ref(12'd1); send_ref(12'd1);
		write_frames(FW'(3));
		foreach (seq[i])
			send_ref(PB'(seq[i]));
		write_frames(FW'(0));
		send_ref(12'd7); send_ref(12'd7); send_ref(12'd8);
		write_frames(FW'(127));
		send_ref(12'hFFF); send_ref(12'h001);

		for (int ph = 0; ph < 12; ph++) begin
			write_frames(FW'(setting[ph]));
			quiet = (ph % 4 == 1);
			n = (setting[ph] < 1) ? 1 : (setting[ph] > NF) ? NF : setting[ph];
			count = (n >= 32) ? 80 : 200;
			base = PB'($urandom);
			for (int i = 0; i < count; i++) begin
				if (ph == 2 && i == 50) long_hold = 1'b1;
				if (ph == 3 && i == 100) drain();
				if ($urandom_range(0, 99) < 85)
					send_ref(base + PB'($urandom_range(0, 2 * n + 1)));
				else
					send_ref(PB'($urandom));
			end
		end
		quiet = 1'b0;
		drain();
		repeat (50) @(negedge clk);
		if (fails == 0)
			$display("** page_replacement_fault_counter_top: PASSED **");
		else
			$display("** page_replacement_fault_counter_top: FAILED **");
		$finish;
	end
endmodule
